// File: sv/lmtc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD mode timing controller - shared definitions
// Command and mode codes, timing constants, state and result words.
// ----------------------------------------------------------------------------
package lmtc_pkg;

   // Frame geometry
   localparam int VISIBLE_LINES = 144;
   localparam int TOTAL_LINES   = 154;

   localparam logic [7:0] VISIBLE_LINE_NUM = 8'(VISIBLE_LINES);
   localparam logic [8:0] TOTAL_LINE_NUM   = 9'(TOTAL_LINES);

   // Clocks spent in each mode
   localparam logic [15:0] OAM_CLOCKS    = 16'd80;
   localparam logic [15:0] XFER_CLOCKS   = 16'd172;
   localparam logic [15:0] HBLANK_CLOCKS = 16'd204;
   localparam logic [15:0] LINE_CLOCKS   = 16'd456;
   localparam logic [15:0] TICK_MAX      = 16'hFFFF;

   // Control byte layout
   localparam logic [7:0] CTRL_RESET      = 8'h91;
   localparam int         CTRL_LCD_ON_BIT = 7;
   localparam int         CTRL_SPRITE_BIT = 1;

   // Status write: enables sit in bits 3 to 6
   localparam int STAT_EN_LSB = 3;
   localparam int STAT_EN_LINE_MATCH = 3;

   // Commands
   localparam logic [2:0] CMD_TICK      = 3'd0;
   localparam logic [2:0] CMD_CTRL      = 3'd1;
   localparam logic [2:0] CMD_LINE_RST  = 3'd2;
   localparam logic [2:0] CMD_STAT_EN   = 3'd3;
   localparam logic [2:0] CMD_CMP_LINE  = 3'd4;

   // Modes
   localparam logic [1:0] MODE_HBLANK = 2'd0;
   localparam logic [1:0] MODE_VBLANK = 2'd1;
   localparam logic [1:0] MODE_OAM    = 2'd2;
   localparam logic [1:0] MODE_XFER   = 2'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  line;
      logic [15:0] tick;
      logic        lcd_on;
      logic        sprites_on;
      logic [3:0]  stat_en;
      logic [7:0]  cmp_line;
      logic        coincide;
   } state_type;

   localparam state_type STATE_RESET = '{
      mode:       MODE_HBLANK,
      line:       8'd0,
      tick:       16'd0,
      lcd_on:     CTRL_RESET[CTRL_LCD_ON_BIT],
      sprites_on: CTRL_RESET[CTRL_SPRITE_BIT],
      stat_en:    4'd0,
      cmp_line:   8'd0,
      coincide:   1'b0
   };

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] line;
      logic [6:0] status_byte;
      logic       vblank_irq;
      logic       stat_irq;
      logic       render_line;
      logic       frame_done;
      logic       render_sprites;
   } result_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic [9:0] clocks;
      logic [7:0] data;
   } item_type;

endpackage

// File: sv/lmtc_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD mode timing controller - input register
// Captures one request word; stalls the sender while the held word waits.
// ----------------------------------------------------------------------------
module lmtc_in_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_cmd,
   input  logic [9:0]         req_clocks,
   input  logic [7:0]         req_data,
   input  logic               advance,
   output logic               item_valid,
   output lmtc_pkg::item_type item
);

   logic               valid_ff;
   logic               valid_in;
   lmtc_pkg::item_type item_ff;
   lmtc_pkg::item_type item_in;
   logic               load;

   assign load      = !valid_ff || advance;
   assign req_stall = !load;
   assign valid_in  = load ? req_valid : valid_ff;

   always_comb begin
      item_in = item_ff;
      if (load && req_valid) begin
         item_in.cmd    = req_cmd;
         item_in.clocks = req_clocks;
         item_in.data   = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: sv/lmtc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD mode timing controller - step logic
// Next state and result word for one command against the present state.
// ----------------------------------------------------------------------------
module lmtc_step (
   input  lmtc_pkg::state_type  cur,
   input  lmtc_pkg::item_type   item,
   output lmtc_pkg::state_type  nxt,
   output lmtc_pkg::result_type res
);

   logic [16:0] tick_sum;
   logic [15:0] tick_sat;
   logic [8:0]  line_inc;
   logic [7:0]  line_next;
   logic        changed;
   logic        vb_irq;
   logic        rline;
   logic        rspr;
   logic        st_irq;
   logic        lcd_on_req;

   assign tick_sum = {1'b0, cur.tick} + {7'd0, item.clocks};
   assign tick_sat = tick_sum[16] ? lmtc_pkg::TICK_MAX : tick_sum[15:0];
   assign line_inc = {1'b0, cur.line} + 9'd1;
   // wrap once the frame's line count is reached
   assign line_next = (line_inc >= lmtc_pkg::TOTAL_LINE_NUM) ? 8'd0 : line_inc[7:0];
   assign lcd_on_req = item.data[lmtc_pkg::CTRL_LCD_ON_BIT];

   always_comb begin
      nxt     = cur;
      changed = 1'b0;
      vb_irq  = 1'b0;
      rline   = 1'b0;
      rspr    = 1'b0;
      st_irq  = 1'b0;
      case (item.cmd)
         lmtc_pkg::CMD_TICK: begin
            if (!cur.lcd_on) begin
               nxt.tick     = 16'd0;
               nxt.line     = 8'd0;
               nxt.mode     = lmtc_pkg::MODE_VBLANK;
               nxt.coincide = 1'b0;
            end else begin
               nxt.tick = tick_sat;
               case (cur.mode)
                  lmtc_pkg::MODE_HBLANK: begin
                     if (tick_sat >= lmtc_pkg::HBLANK_CLOCKS) begin
                        nxt.line = line_next;
                        changed  = 1'b1;
                        nxt.tick = tick_sat - lmtc_pkg::HBLANK_CLOCKS;
                        if (line_next == lmtc_pkg::VISIBLE_LINE_NUM) begin
                           nxt.mode = lmtc_pkg::MODE_VBLANK;
                           vb_irq   = 1'b1;
                           rspr     = cur.sprites_on;
                        end else begin
                           nxt.mode = lmtc_pkg::MODE_OAM;
                        end
                     end
                  end
                  lmtc_pkg::MODE_VBLANK: begin
                     if (tick_sat >= lmtc_pkg::LINE_CLOCKS) begin
                        nxt.tick = tick_sat - lmtc_pkg::LINE_CLOCKS;
                        // at line 0 vblank only hands over to OAM search
                        nxt.line = (cur.line == 8'd0) ? 8'd0 : line_next;
                        if (cur.line == 8'd0 || line_next == 8'd0) begin
                           nxt.mode = lmtc_pkg::MODE_OAM;
                           changed  = 1'b1;
                        end
                     end
                  end
                  lmtc_pkg::MODE_OAM: begin
                     if (tick_sat >= lmtc_pkg::OAM_CLOCKS) begin
                        nxt.mode = lmtc_pkg::MODE_XFER;
                        changed  = 1'b1;
                        nxt.tick = tick_sat - lmtc_pkg::OAM_CLOCKS;
                     end
                  end
                  default: begin
                     if (tick_sat >= lmtc_pkg::XFER_CLOCKS) begin
                        nxt.mode = lmtc_pkg::MODE_HBLANK;
                        changed  = 1'b1;
                        rline    = 1'b1;
                        nxt.tick = tick_sat - lmtc_pkg::XFER_CLOCKS;
                     end
                  end
               endcase
               nxt.coincide = (nxt.line == cur.cmp_line);
               if (changed && nxt.mode != lmtc_pkg::MODE_XFER
                   && cur.stat_en[nxt.mode]) begin
                  st_irq = 1'b1;
               end
               if (nxt.coincide && cur.stat_en[lmtc_pkg::STAT_EN_LINE_MATCH]) begin
                  st_irq = 1'b1;
               end
            end
         end
         lmtc_pkg::CMD_CTRL: begin
            nxt.sprites_on = item.data[lmtc_pkg::CTRL_SPRITE_BIT];
            nxt.lcd_on     = lcd_on_req;
            if (lcd_on_req && !cur.lcd_on) begin
               nxt.line = 8'd0;
               nxt.mode = lmtc_pkg::MODE_HBLANK;
               nxt.tick = 16'd0;
            end
         end
         lmtc_pkg::CMD_LINE_RST: begin
            nxt.line = 8'd0;
            nxt.tick = 16'd0;
            nxt.mode = lmtc_pkg::MODE_HBLANK;
         end
         lmtc_pkg::CMD_STAT_EN: begin
            nxt.stat_en = item.data[lmtc_pkg::STAT_EN_LSB +: 4];
         end
         lmtc_pkg::CMD_CMP_LINE: begin
            nxt.cmp_line = item.data;
         end
         default: begin
            // unused command: report present state
         end
      endcase

      res.mode           = nxt.mode;
      res.line           = nxt.line;
      res.status_byte    = {nxt.stat_en, nxt.coincide, nxt.mode};
      res.vblank_irq     = vb_irq;
      res.stat_irq       = st_irq;
      res.render_line    = rline;
      res.frame_done     = vb_irq;
      res.render_sprites = rspr;
   end

endmodule

// File: sv/lcd_mode_timing_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD mode timing controller - top level
// Scan timing state, status byte and interrupt pulses for an LCD.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): one word per tick or register write; cmd selects
//   tick, control write, line reset, status enable write or compare write.
//   Result channel (rsp_*): exactly one word per request, in order, giving
//   mode, line, status byte and the one-word interrupt and render pulses.
//   Path: a word accepted is registered in the input register, stepped
//   against the timing state and registered in the result register for rsp_*.
//   Throughput: one word per cycle unless stalled; the step is a single
//   pass of compares and one subtract between the input and result registers.
//   Reset: timing state returns to hblank, line 0, LCD on, enables and
//   compare line cleared; both channels empty.
//   Stall: while rsp_stall holds a result, one further request is still
//   taken into the input register; req_stall rises only once that is full.
// ----------------------------------------------------------------------------
module lcd_mode_timing_controller_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_cmd,
   input  logic [9:0] req_clocks,
   input  logic [7:0] req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_mode,
   output logic [7:0] rsp_line,
   output logic [6:0] rsp_status_byte,
   output logic       rsp_vblank_irq,
   output logic       rsp_stat_irq,
   output logic       rsp_render_line,
   output logic       rsp_frame_done,
   output logic       rsp_render_sprites
);

   logic                 advance;
   logic                 item_valid;
   lmtc_pkg::item_type   item;
   lmtc_pkg::state_type  state_ff;
   lmtc_pkg::state_type  state_in;
   lmtc_pkg::state_type  step_state;
   lmtc_pkg::result_type step_res;
   lmtc_pkg::result_type res_ff;
   lmtc_pkg::result_type res_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 take;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign take    = advance && item_valid;

   lmtc_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_cmd    (req_cmd),
      .req_clocks (req_clocks),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   lmtc_step u_step (
      .cur  (state_ff),
      .item (item),
      .nxt  (step_state),
      .res  (step_res)
   );

   assign state_in     = take ? step_state : state_ff;
   assign res_in       = take ? step_res : res_ff;
   assign rsp_valid_in = advance ? item_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lmtc_pkg::STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mode           = res_ff.mode;
   assign rsp_line           = res_ff.line;
   assign rsp_status_byte    = res_ff.status_byte;
   assign rsp_vblank_irq     = res_ff.vblank_irq;
   assign rsp_stat_irq       = res_ff.stat_irq;
   assign rsp_render_line    = res_ff.render_line;
   assign rsp_frame_done     = res_ff.frame_done;
   assign rsp_render_sprites = res_ff.render_sprites;

   // line stays inside the frame
   assert property (@(posedge clock) disable iff (reset)
      {1'b0, state_ff.line} < lmtc_pkg::TOTAL_LINE_NUM)
      else $error("line left the frame");

   // a tick with the panel off parks it in vblank at line 0
   assert property (@(posedge clock) disable iff (reset)
      take && item.cmd == lmtc_pkg::CMD_TICK && !state_ff.lcd_on
      |=> state_ff.mode == lmtc_pkg::MODE_VBLANK && state_ff.line == 8'd0
          && state_ff.tick == 16'd0)
      else $error("panel off tick did not park in vblank");

   // frame end only on entry to vblank at the first hidden line
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_ff.frame_done
      |-> res_ff.mode == lmtc_pkg::MODE_VBLANK
          && res_ff.line == lmtc_pkg::VISIBLE_LINE_NUM)
      else $error("frame end outside vblank entry");

   // a rendered line always leaves the block in hblank
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_ff.render_line |-> res_ff.mode == lmtc_pkg::MODE_HBLANK)
      else $error("render pulse outside hblank");

   // a held result does not move the timing state behind it
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> $stable(state_ff))
      else $error("state moved under a stalled result");

endmodule

// File: tb/sv/lcd_mode_timing_controller_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD mode timing controller - testbench
// Drives tick and register words into the controller and checks every result
// word against a typed table entry or a cycle-free model of the scan timing.
// A short table of directed words opens the run; random frame runs, noise,
// tick saturation bursts and LCD off episodes follow, under changing sender
// and receiver idling.
// ----------------------------------------------------------------------------
module lcd_mode_timing_controller_top_tb;

   localparam int ITEM_TARGET    = 1900;
   localparam int PHASE_ITEMS    = 200;
   localparam int IDLE_HEAVY_PCT = 74;
   localparam int IDLE_LIGHT_PCT = 6;
   localparam int SETTLE_CYCLES  = 8;
   localparam int MAX_REPORTS    = 10;

   // Command codes the block does not decode
   localparam logic [2:0] CMD_SPARE_5 = 3'd5;
   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;

   localparam logic [4:0] NO_PULSES = 5'b00000;

   typedef enum int {
      FLOW_FREE,
      FLOW_SENDER_IDLE,
      FLOW_RECEIVER_STALL,
      FLOW_BOTH
   } flow_phase_type;

   typedef struct packed {
      lmtc_pkg::item_type   word;
      logic                 typed;
      lmtc_pkg::result_type want;
   } dir_row_type;

   typedef struct {
      logic [1:0]  mode;
      logic [7:0]  line;
      logic [15:0] ticks;
      logic        lcd_on;
      logic [7:0]  ctrl;
      logic [3:0]  stat_en;
      logic [7:0]  cmp_line;
      logic        coincide;
   } scan_model_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_cmd = '0;
   logic [9:0] req_clocks = '0;
   logic [7:0] req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_mode;
   logic [7:0] rsp_line;
   logic [6:0] rsp_status_byte;
   logic       rsp_vblank_irq;
   logic       rsp_stat_irq;
   logic       rsp_render_line;
   logic       rsp_frame_done;
   logic       rsp_render_sprites;

   scan_model_type       scan;
   lmtc_pkg::result_type pending_results[$];
   lmtc_pkg::result_type seen_word;
   lmtc_pkg::result_type wanted_word;
   flow_phase_type       flow = FLOW_FREE;
   int                   counted = 0;
   int                   mismatches = 0;

   dir_row_type directed [22] = '{
      '{'{lmtc_pkg::CMD_TICK,     10'd0,    8'h00}, 1'b1,
        {lmtc_pkg::MODE_HBLANK, 8'd0, 7'h04, NO_PULSES}},
      '{'{CMD_SPARE_5,            10'd1023, 8'hFF}, 1'b1,
        {lmtc_pkg::MODE_HBLANK, 8'd0, 7'h04, NO_PULSES}},
      '{'{CMD_SPARE_6,            10'd0,    8'h00}, 1'b1,
        {lmtc_pkg::MODE_HBLANK, 8'd0, 7'h04, NO_PULSES}},
      '{'{CMD_SPARE_7,            10'd512,  8'h55}, 1'b1,
        {lmtc_pkg::MODE_HBLANK, 8'd0, 7'h04, NO_PULSES}},
      '{'{lmtc_pkg::CMD_STAT_EN,  10'd0,    8'hFF}, 1'b1,
        {lmtc_pkg::MODE_HBLANK, 8'd0, 7'h7C, NO_PULSES}},
      '{'{lmtc_pkg::CMD_CMP_LINE, 10'd0,    8'hFF}, 1'b1,
        {lmtc_pkg::MODE_HBLANK, 8'd0, 7'h7C, NO_PULSES}},
      '{'{lmtc_pkg::CMD_TICK,     10'd0,    8'h00}, 1'b1,
        {lmtc_pkg::MODE_HBLANK, 8'd0, 7'h78, NO_PULSES}},
      '{'{lmtc_pkg::CMD_TICK,     10'd1023, 8'h00}, 1'b0, '0},
      '{'{lmtc_pkg::CMD_TICK,     10'd1023, 8'h00}, 1'b0, '0},
      '{'{lmtc_pkg::CMD_TICK,     10'd1023, 8'h00}, 1'b0, '0},
      '{'{lmtc_pkg::CMD_STAT_EN,  10'd0,    8'h00}, 1'b0, '0},
      '{'{lmtc_pkg::CMD_CMP_LINE, 10'd0,    8'h01}, 1'b0, '0},
      '{'{lmtc_pkg::CMD_TICK,     10'd0,    8'h00}, 1'b0, '0},
      '{'{lmtc_pkg::CMD_STAT_EN,  10'd0,    8'h40}, 1'b0, '0},
      '{'{lmtc_pkg::CMD_TICK,     10'd0,    8'h00}, 1'b0, '0},
      '{'{lmtc_pkg::CMD_CTRL,     10'd0,    8'h00}, 1'b0, '0},
      '{'{lmtc_pkg::CMD_TICK,     10'd1023, 8'h00}, 1'b1,
        {lmtc_pkg::MODE_VBLANK, 8'd0, 7'h41, NO_PULSES}},
      '{'{lmtc_pkg::CMD_LINE_RST, 10'd0,    8'h00}, 1'b1,
        {lmtc_pkg::MODE_HBLANK, 8'd0, 7'h40, NO_PULSES}},
      '{'{lmtc_pkg::CMD_TICK,     10'd5,    8'h00}, 1'b0, '0},
      '{'{lmtc_pkg::CMD_CTRL,     10'd0,    8'hFF}, 1'b0, '0},
      '{'{lmtc_pkg::CMD_TICK,     10'd1023, 8'h00}, 1'b0, '0},
      '{'{lmtc_pkg::CMD_LINE_RST, 10'd0,    8'h00}, 1'b0, '0}
   };

   lcd_mode_timing_controller_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_clocks         (req_clocks),
      .req_data           (req_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_mode           (rsp_mode),
      .rsp_line           (rsp_line),
      .rsp_status_byte    (rsp_status_byte),
      .rsp_vblank_irq     (rsp_vblank_irq),
      .rsp_stat_irq       (rsp_stat_irq),
      .rsp_render_line    (rsp_render_line),
      .rsp_frame_done     (rsp_frame_done),
      .rsp_render_sprites (rsp_render_sprites)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic [7:0] following_line(input logic [7:0] cur);
      int unsigned nxt;
      nxt = 32'(cur) + 1;
      if (nxt >= lmtc_pkg::TOTAL_LINES) nxt = 0;
      return nxt[7:0];
   endfunction

   // One word through the scan timing; updates the model and returns the result
   function automatic lmtc_pkg::result_type advance_scan(input lmtc_pkg::item_type w);
      lmtc_pkg::result_type r;
      int unsigned          sum;
      logic                 changed;
      r = '0;
      changed = 1'b0;
      case (w.cmd)
         lmtc_pkg::CMD_TICK: begin
            if (!scan.lcd_on) begin
               scan.ticks = '0;
               scan.line = '0;
               scan.mode = lmtc_pkg::MODE_VBLANK;
               scan.coincide = 1'b0;
            end else begin
               sum = 32'(scan.ticks) + 32'(w.clocks);
               if (sum > 32'(lmtc_pkg::TICK_MAX)) sum = 32'(lmtc_pkg::TICK_MAX);
               scan.ticks = sum[15:0];
               case (scan.mode)
                  lmtc_pkg::MODE_HBLANK: begin
                     if (scan.ticks >= lmtc_pkg::HBLANK_CLOCKS) begin
                        scan.line = following_line(scan.line);
                        if (scan.line == lmtc_pkg::VISIBLE_LINE_NUM) begin
                           scan.mode = lmtc_pkg::MODE_VBLANK;
                           r.render_sprites = scan.ctrl[lmtc_pkg::CTRL_SPRITE_BIT];
                           r.vblank_irq = 1'b1;
                           r.frame_done = 1'b1;
                        end else begin
                           scan.mode = lmtc_pkg::MODE_OAM;
                        end
                        changed = 1'b1;
                        scan.ticks = scan.ticks - lmtc_pkg::HBLANK_CLOCKS;
                     end
                  end
                  lmtc_pkg::MODE_VBLANK: begin
                     if (scan.ticks >= lmtc_pkg::LINE_CLOCKS) begin
                        // line 0 in vblank stays at 0 and leaves for oam search
                        if (scan.line != 8'd0) scan.line = following_line(scan.line);
                        if (scan.line == 8'd0) begin
                           scan.mode = lmtc_pkg::MODE_OAM;
                           changed = 1'b1;
                        end
                        scan.ticks = scan.ticks - lmtc_pkg::LINE_CLOCKS;
                     end
                  end
                  lmtc_pkg::MODE_OAM: begin
                     if (scan.ticks >= lmtc_pkg::OAM_CLOCKS) begin
                        scan.mode = lmtc_pkg::MODE_XFER;
                        changed = 1'b1;
                        scan.ticks = scan.ticks - lmtc_pkg::OAM_CLOCKS;
                     end
                  end
                  default: begin
                     if (scan.ticks >= lmtc_pkg::XFER_CLOCKS) begin
                        scan.mode = lmtc_pkg::MODE_HBLANK;
                        changed = 1'b1;
                        r.render_line = 1'b1;
                        scan.ticks = scan.ticks - lmtc_pkg::XFER_CLOCKS;
                     end
                  end
               endcase
               scan.coincide = (scan.line == scan.cmp_line);
               if (changed && scan.mode != lmtc_pkg::MODE_XFER && scan.stat_en[scan.mode])
                  r.stat_irq = 1'b1;
               if (scan.coincide && scan.stat_en[lmtc_pkg::STAT_EN_LINE_MATCH])
                  r.stat_irq = 1'b1;
            end
         end
         lmtc_pkg::CMD_CTRL: begin
            scan.ctrl = w.data;
            if (w.data[lmtc_pkg::CTRL_LCD_ON_BIT] && !scan.lcd_on) begin
               scan.lcd_on = 1'b1;
               scan.line = '0;
               scan.mode = lmtc_pkg::MODE_HBLANK;
               scan.ticks = '0;
            end else if (!w.data[lmtc_pkg::CTRL_LCD_ON_BIT] && scan.lcd_on) begin
               scan.lcd_on = 1'b0;
            end
         end
         lmtc_pkg::CMD_LINE_RST: begin
            scan.line = '0;
            scan.ticks = '0;
            scan.mode = lmtc_pkg::MODE_HBLANK;
         end
         lmtc_pkg::CMD_STAT_EN: scan.stat_en = w.data[lmtc_pkg::STAT_EN_LSB +: 4];
         lmtc_pkg::CMD_CMP_LINE: scan.cmp_line = w.data;
         default: ;
      endcase
      r.mode = scan.mode;
      r.line = scan.line;
      r.status_byte = {scan.stat_en, scan.coincide, scan.mode};
      return r;
   endfunction

   // Tick length aimed mostly at stepping, sometimes right at a mode boundary
   function automatic logic [9:0] pick_tick_clocks();
      int unsigned need;
      int unsigned roll;
      case (scan.mode)
         lmtc_pkg::MODE_HBLANK: need = 32'(lmtc_pkg::HBLANK_CLOCKS);
         lmtc_pkg::MODE_VBLANK: need = 32'(lmtc_pkg::LINE_CLOCKS);
         lmtc_pkg::MODE_OAM:    need = 32'(lmtc_pkg::OAM_CLOCKS);
         default:               need = 32'(lmtc_pkg::XFER_CLOCKS);
      endcase
      roll = $urandom_range(99);
      if (roll < 45) return 10'($urandom_range(1023));
      if (roll < 65) return 10'($urandom_range(63));
      if (roll < 90 && 32'(scan.ticks) < need) begin
         need = need - 32'(scan.ticks) + $urandom_range(2);
         return 10'(need - 1);
      end
      if (roll < 96) return 10'd1023;
      return 10'($urandom);
   endfunction

   task automatic log_fault(input string what, input lmtc_pkg::result_type want,
                            input lmtc_pkg::result_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t %s (expected/actual): mode %0d/%0d line %0d/%0d status %02h/%02h",
                  $realtime, what, want.mode, got.mode, want.line, got.line,
                  want.status_byte, got.status_byte,
                  "  vblank %b/%b stat %b/%b render %b/%b frame %b/%b sprites %b/%b",
                  want.vblank_irq, got.vblank_irq, want.stat_irq, got.stat_irq,
                  want.render_line, got.render_line, want.frame_done, got.frame_done,
                  want.render_sprites, got.render_sprites);
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance
   task automatic send_word(input lmtc_pkg::item_type w, input logic typed = 1'b0,
                            input lmtc_pkg::result_type want = '0);
      int                   gaps;
      int                   pct;
      lmtc_pkg::result_type predicted;
      gaps = 0;
      pct = (flow == FLOW_SENDER_IDLE) ? IDLE_HEAVY_PCT :
            (flow == FLOW_BOTH) ? IDLE_LIGHT_PCT : 0;
      while ($urandom_range(99) < pct) gaps++;
      if (gaps > 0) begin
         req_valid <= 1'b0;
         repeat (gaps) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= w.cmd;
      req_clocks <= w.clocks;
      req_data <= w.data;
      do @(posedge clock); while (req_stall);
      predicted = advance_scan(w);
      pending_results.push_back(typed ? want : predicted);
      if (w.cmd <= lmtc_pkg::CMD_CMP_LINE) counted++;
      @(negedge clock);
   endtask

   // Hold the sender until every pending result word is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < ((flow == FLOW_RECEIVER_STALL) ? IDLE_HEAVY_PCT :
                                         (flow == FLOW_BOTH) ? IDLE_LIGHT_PCT : 0));
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_word = '{rsp_mode, rsp_line, rsp_status_byte, rsp_vblank_irq, rsp_stat_irq,
                       rsp_render_line, rsp_frame_done, rsp_render_sprites};
         if (pending_results.size() == 0) begin
            log_fault("result word with nothing pending", '0, seen_word);
         end else begin
            wanted_word = pending_results.pop_front();
            if (seen_word.mode !== wanted_word.mode ||
                seen_word.line !== wanted_word.line ||
                seen_word.status_byte !== wanted_word.status_byte ||
                seen_word.vblank_irq !== wanted_word.vblank_irq ||
                seen_word.stat_irq !== wanted_word.stat_irq ||
                seen_word.render_line !== wanted_word.render_line ||
                seen_word.frame_done !== wanted_word.frame_done ||
                seen_word.render_sprites !== wanted_word.render_sprites)
               log_fault("result word mismatch", wanted_word, seen_word);
         end
      end
   end

   initial begin
      lmtc_pkg::item_type w;
      int                 roll;
      int                 pick;
      int                 run_len;
      int                 phase_end;
      logic               first_run;

      scan.mode = lmtc_pkg::MODE_HBLANK;
      scan.line = '0;
      scan.ticks = '0;
      scan.lcd_on = lmtc_pkg::CTRL_RESET[lmtc_pkg::CTRL_LCD_ON_BIT];
      scan.ctrl = lmtc_pkg::CTRL_RESET;
      scan.stat_en = '0;
      scan.cmp_line = '0;
      scan.coincide = 1'b0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_word(directed[i].word, directed[i].typed, directed[i].want);

      first_run = 1'b1;
      phase_end = counted + PHASE_ITEMS;
      while (counted < ITEM_TARGET + $size(directed)) begin
         if (counted >= phase_end) begin
            wait_drained();
            flow = flow_phase_type'((int'(flow) + 1) % 4);
            phase_end = counted + PHASE_ITEMS;
         end
         roll = first_run ? 0 : $urandom_range(99);
         if (roll < 55) begin
            // frame run: mostly ticks, the odd register write
            run_len = first_run ? 800 : $urandom_range(400, 40);
            repeat (run_len) begin
               pick = $urandom_range(99);
               if (pick < 90)
                  w = '{lmtc_pkg::CMD_TICK, pick_tick_clocks(), 8'($urandom)};
               else if (pick < 94)
                  w = '{lmtc_pkg::CMD_CMP_LINE, 10'($urandom),
                        ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(153))};
               else if (pick < 97)
                  w = '{lmtc_pkg::CMD_STAT_EN, 10'($urandom), 8'($urandom)};
               else if (pick < 99)
                  w = '{lmtc_pkg::CMD_CTRL, 10'($urandom), {1'b1, 7'($urandom)}};
               else
                  w = '{3'($urandom_range(CMD_SPARE_7, CMD_SPARE_5)), 10'($urandom),
                        8'($urandom)};
               send_word(w);
            end
         end else if (roll < 80) begin
            repeat ($urandom_range(24, 8)) begin
               w = '{3'($urandom), 10'($urandom), 8'($urandom)};
               if (w.cmd == lmtc_pkg::CMD_TICK && $urandom_range(1))
                  w.clocks = pick_tick_clocks();
               send_word(w);
            end
            if (!scan.lcd_on)
               send_word('{lmtc_pkg::CMD_CTRL, 10'($urandom), {1'b1, 7'($urandom)}});
         end else if (roll < 88) begin
            // push the tick counter into saturation, then clear it
            repeat (90) send_word('{lmtc_pkg::CMD_TICK, 10'd1023, 8'($urandom)});
            send_word('{lmtc_pkg::CMD_LINE_RST, 10'($urandom), 8'($urandom)});
         end else begin
            send_word('{lmtc_pkg::CMD_CTRL, 10'($urandom), {1'b0, 7'($urandom)}});
            repeat ($urandom_range(6, 1)) begin
               w = '{3'($urandom_range(lmtc_pkg::CMD_CMP_LINE)), 10'($urandom),
                     8'($urandom)};
               if (w.cmd == lmtc_pkg::CMD_CTRL) w.data[lmtc_pkg::CTRL_LCD_ON_BIT] = 1'b0;
               if (w.cmd == lmtc_pkg::CMD_TICK) w.clocks = pick_tick_clocks();
               send_word(w);
            end
            send_word('{lmtc_pkg::CMD_CTRL, 10'($urandom), {1'b1, 7'($urandom)}});
         end
         first_run = 1'b0;
      end

      flow = FLOW_FREE;
      wait_drained();
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
